// File: src/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared constants, types and helpers of the 3x3 percentage-closer shadow test.
// ----------------------------------------------------------------------------
package pcf_pkg;

	localparam int KernelTaps = 9;
	localparam int FracW      = 17;
	localparam int CoordW     = 18;
	localparam int CountW     = 4;

	localparam logic [2:0] RegRow0  = 3'd0;
	localparam logic [2:0] RegRow1  = 3'd1;
	localparam logic [2:0] RegRow2  = 3'd2;
	localparam logic [2:0] RegRow3  = 3'd3;
	localparam logic [2:0] RegBias  = 3'd4;
	localparam logic [2:0] RegStep  = 3'd5;

	localparam logic KindRequest = 1'b0;
	localparam logic KindFinal   = 1'b1;
	localparam logic ModeFrag    = 1'b0;

	// divider handshake between the sequencer and the shared divider
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [FracW-1:0] quo;
	} div_rsp_t;

	// round-to-nearest of count*65536/9
	function automatic logic [FracW-1:0] lit_frac(input logic [CountW-1:0] cnt);
		logic [FracW-1:0] f;
		case (cnt)
			4'd0: f = 17'd0;
			4'd1: f = 17'd7282;
			4'd2: f = 17'd14564;
			4'd3: f = 17'd21845;
			4'd4: f = 17'd29127;
			4'd5: f = 17'd36409;
			4'd6: f = 17'd43691;
			4'd7: f = 17'd50972;
			4'd8: f = 17'd58254;
			4'd9: f = 17'd65536;
			default: f = 17'd0;
		endcase
		return f;
	endfunction

endpackage

// File: src/pcf_div.sv
// ----------------------------------------------------------------------------
// pcf_div
// Restoring divider, one quotient bit per cycle: floor(num*2^16/den), 17 bits.
// ----------------------------------------------------------------------------
module pcf_div import pcf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [64:0]      rem_q;
	logic [63:0]      den_q;
	logic [FracW-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	logic             ge;
	logic [64:0]      rem_n;

	assign ge    = rem_q >= {1'b0, den_q};
	assign rem_n = ge ? rem_q - {1'b0, den_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == 5'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(FracW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_n[63:0], 1'b0};
			quo_q <= {quo_q[FracW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// File: src/pcf_shadow_test.sv
// ----------------------------------------------------------------------------
// pcf_shadow_test
// 3x3 percentage-closer shadow test with light-space transform and divide.
// ----------------------------------------------------------------------------
// A fragment transfer (tuser 0) is transformed by one shared 16x32 multiplier,
// twelve products, each in a multiply and an accumulate state, plus a range
// check; then three divides of 17 steps on one shared divider give u, v and
// depth before the first of the nine sample requests leaves, then one per cycle
// as the sink takes them.
// A rejected fragment gives one fully lit final result.
// Each depth transfer (tuser 1) is taken while idle; the ninth of a run leads
// to the final result. Input is held off while a result is pending or the
// sequencer is busy.
module pcf_shadow_test import pcf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,  // pos_x, pos_y, pos_z, sample_depth
	input  logic         s_tuser,  // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // sample_u, sample_v, lit_count, lit_fraction, zero pad
	output logic         m_tuser,  // kind
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_CHECK, ST_DIVGO, ST_DIVW, ST_EMIT, ST_FINAL
	} state_t;

	state_t state_q;

	logic [63:0] mat_q [4];
	logic [15:0] bias_q;
	logic [15:0] step_q;

	logic signed [31:0] pos_q [3];
	logic signed [63:0] clip_q [4];
	logic signed [63:0] acc_q;
	logic signed [47:0] prod_q;
	logic [1:0]         row_q;
	logic [1:0]         col_q;
	logic [1:0]         dsel_q;
	logic [FracW-1:0]   u_q, v_q, fd_q;
	logic [3:0]         left_q;
	logic [CountW-1:0]  pass_q;
	logic [CountW-1:0]  fin_cnt_q;
	logic [1:0]         tx_q, ty_q;

	logic               m_valid_q, m_kind_q, m_last_q;
	logic [CoordW-1:0]  m_u_q, m_v_q;
	logic [CountW-1:0]  m_cnt_q;
	logic [FracW-1:0]   m_frac_q;

	div_req_t dreq;
	div_rsp_t drsp;

	pcf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE) && !m_valid_q;

	logic s_xfer, m_free, m_load;
	assign s_xfer = s_tvalid && s_tready;
	assign m_free = !m_valid_q || m_tready;
	assign m_load = m_free && ((state_q == ST_EMIT) || (state_q == ST_FINAL));

	// shared multiplier operands
	logic signed [15:0] mul_a;
	logic signed [31:0] mul_b;
	logic [63:0]        row_sel;
	assign row_sel = mat_q[row_q];
	assign mul_a   = signed'(row_sel[16*col_q +: 16]);
	assign mul_b   = pos_q[col_q];

	logic signed [63:0] w_init;
	always_comb begin
		logic [15:0] m3;
		m3     = mat_q[row_q][63:48];
		w_init = signed'({{20{m3[15]}}, m3, 28'd0});
	end

	logic signed [63:0] cx, cy, cz, cw;
	logic               reject;
	assign cx = clip_q[0];
	assign cy = clip_q[1];
	assign cz = clip_q[2];
	assign cw = clip_q[3];
	assign reject = (cw <= 0) || (cx < -cw) || (cx > cw) || (cy < -cw) || (cy > cw)
		|| (cz < 0) || (cz > cw);

	always_comb begin
		dreq.start = (state_q == ST_DIVGO);
		case (dsel_q)
			2'd0: begin dreq.num = 64'(cx + cw); dreq.den = 64'(cw <<< 1); end
			2'd1: begin dreq.num = 64'(cy + cw); dreq.den = 64'(cw <<< 1); end
			default: begin dreq.num = 64'(cz); dreq.den = 64'(cw); end
		endcase
	end

	// depth test in wide signed arithmetic
	logic signed [18:0] lhs;
	logic               pass;
	logic [CountW-1:0]  pass_n;
	assign lhs    = signed'({2'b00, fd_q}) - 19'(signed'(bias_q));
	assign pass   = lhs <= signed'({3'b000, s_tdata[111:96]});
	assign pass_n = pass ? pass_q + 4'd1 : pass_q;

	logic [CoordW-1:0] u_ext, v_ext, st_ext, su, sv;
	assign u_ext  = {1'b0, u_q};
	assign v_ext  = {1'b0, v_q};
	assign st_ext = {2'b00, step_q};
	always_comb begin
		case (tx_q)
			2'd0:    su = u_ext - st_ext;
			2'd1:    su = u_ext;
			default: su = u_ext + st_ext;
		endcase
		case (ty_q)
			2'd0:    sv = v_ext - st_ext;
			2'd1:    sv = v_ext;
			default: sv = v_ext + st_ext;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) mat_q[i] <= '0;
			bias_q <= '0;
			step_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegRow0: mat_q[0] <= cfg_data;
				RegRow1: mat_q[1] <= cfg_data;
				RegRow2: mat_q[2] <= cfg_data;
				RegRow3: mat_q[3] <= cfg_data;
				RegBias: bias_q   <= cfg_data[15:0];
				RegStep: step_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			m_kind_q  <= 1'b0;
			m_last_q  <= 1'b0;
			m_u_q     <= '0;
			m_v_q     <= '0;
			m_cnt_q   <= '0;
			m_frac_q  <= '0;
			for (int i = 0; i < 3; i++) pos_q[i] <= '0;
			for (int i = 0; i < 4; i++) clip_q[i] <= '0;
			acc_q     <= '0;
			prod_q    <= '0;
			u_q       <= '0;
			v_q       <= '0;
			left_q    <= '0;
			pass_q    <= '0;
			fd_q      <= '0;
			row_q     <= '0;
			col_q     <= '0;
			dsel_q    <= '0;
			tx_q      <= '0;
			ty_q      <= '0;
			fin_cnt_q <= '0;
		end else begin
			if (m_valid_q && m_tready && !m_load) m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						if (s_tuser == ModeFrag) begin
							pos_q[0] <= signed'(s_tdata[31:0]);
							pos_q[1] <= signed'(s_tdata[63:32]);
							pos_q[2] <= signed'(s_tdata[95:64]);
							left_q   <= '0;
							pass_q   <= '0;
							row_q    <= '0;
							col_q    <= '0;
							state_q  <= ST_MUL;
						end else if (left_q != 4'd0) begin
							left_q <= left_q - 4'd1;
							if (left_q == 4'd1) begin
								fin_cnt_q <= pass_n;
								pass_q    <= '0;
								state_q   <= ST_FINAL;
							end else begin
								pass_q <= pass_n;
							end
						end
					end
				end
				ST_MUL: begin
					prod_q <= mul_a * mul_b;
					if (col_q == 2'd0) acc_q <= w_init;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (col_q == 2'd2) begin
						clip_q[row_q] <= acc_q + 64'(prod_q);
						col_q <= '0;
						row_q <= row_q + 2'd1;
						state_q <= (row_q == 2'd3) ? ST_CHECK : ST_MUL;
					end else begin
						acc_q <= acc_q + 64'(prod_q);
						col_q <= col_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_CHECK: begin
					dsel_q <= '0;
					if (reject) begin
						fin_cnt_q <= 4'(KernelTaps);
						state_q   <= ST_FINAL;
					end else begin
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (drsp.done) begin
						case (dsel_q)
							2'd0:    u_q  <= drsp.quo;
							2'd1:    v_q  <= drsp.quo;
							default: fd_q <= drsp.quo;
						endcase
						dsel_q <= dsel_q + 2'd1;
						if (dsel_q == 2'd2) begin
							tx_q    <= '0;
							ty_q    <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DIVGO;
						end
					end
				end
				ST_EMIT: begin
					if (m_free) begin
						m_valid_q <= 1'b1;
						m_kind_q  <= KindRequest;
						m_u_q     <= su;
						m_v_q     <= sv;
						m_cnt_q   <= '0;
						m_frac_q  <= '0;
						m_last_q  <= (tx_q == 2'd2) && (ty_q == 2'd2);
						if (tx_q == 2'd2) begin
							tx_q <= '0;
							ty_q <= ty_q + 2'd1;
							if (ty_q == 2'd2) begin
								left_q  <= 4'(KernelTaps);
								state_q <= ST_IDLE;
							end
						end else begin
							tx_q <= tx_q + 2'd1;
						end
					end
				end
				ST_FINAL: begin
					if (m_free) begin
						m_valid_q <= 1'b1;
						m_kind_q  <= KindFinal;
						m_u_q     <= '0;
						m_v_q     <= '0;
						m_cnt_q   <= fin_cnt_q;
						m_frac_q  <= lit_frac(fin_cnt_q);
						m_last_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {7'd0, m_frac_q, m_cnt_q, m_v_q, m_u_q};

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KindFinal) |-> m_tlast)
		else $error("final result without tlast");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= 4'(KernelTaps))
		else $error("sample counter out of range");

	a_frag_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ModeFrag) |=> !s_tready)
		else $error("input taken during fragment work");

	a_req_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KindRequest) |-> (m_tdata[39:36] == 4'd0))
		else $error("request carries a count");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// pcf shadow test bench
// Drives fragment and depth transfers with random bursts and gaps, predicts
// the sample requests and lit fractions, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import pcf_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [15:0] sdepth;
	} frag_item_t;

	typedef struct packed {
		logic                     kind;
		logic signed [CoordW-1:0] su;
		logic signed [CoordW-1:0] sv;
		logic [CountW-1:0]        cnt;
		logic [FracW-1:0]         frac;
		logic                     last;
	} shade_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;

	pcf_shadow_test dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [63:0]        mat_row [4];
	logic signed [15:0] bias_q;
	logic [15:0]        step_q;
	logic [16:0]        frag_z;
	int                 taps_due;
	int                 taps_lit;

	frag_item_t    item_q [$];
	shade_result_t shade_q [$];
	int            errors = 0;
	bit            sender_hold = 0;
	bit            sink_block = 0;

	function automatic logic [16:0] frac_quot(logic [63:0] n, logic [63:0] d);
		logic [63:0] r;
		logic [16:0] q;
		r = n;
		q = '0;
		for (int i = 0; i < 17; i++) begin
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
			r = r << 1;
		end
		return q;
	endfunction

	function automatic longint row_product(int row, longint x, longint y, longint z);
		longint m [4];
		for (int c = 0; c < 4; c++)
			m[c] = longint'($signed(mat_row[row][16*c +: 16]));
		return m[0] * x + m[1] * y + m[2] * z + m[3] * 64'sd268435456;
	endfunction

	function automatic shade_result_t lit_result(int count);
		shade_result_t r;
		r = '0;
		r.kind = KindFinal;
		r.cnt = count[3:0];
		r.frac = 17'((count * 65536 + 4) / 9);
		r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_shade(frag_item_t it);
		longint x, y, z, cx, cy, cz, w;
		int u, v, k;
		shade_result_t r;
		if (it.mode == ModeFrag) begin
			x = longint'($signed(it.px));
			y = longint'($signed(it.py));
			z = longint'($signed(it.pz));
			cx = row_product(0, x, y, z);
			cy = row_product(1, x, y, z);
			cz = row_product(2, x, y, z);
			w = row_product(3, x, y, z);
			taps_due = 0;
			taps_lit = 0;
			if (w <= 0 || cx < -w || cx > w || cy < -w || cy > w || cz < 0 || cz > w) begin
				shade_q.push_back(lit_result(9));
				return;
			end
			u = int'(frac_quot(cx + w, w * 2));
			v = int'(frac_quot(cy + w, w * 2));
			frag_z = frac_quot(cz, w);
			k = 0;
			for (int dy = -1; dy <= 1; dy++)
				for (int dx = -1; dx <= 1; dx++) begin
					r = '0;
					r.kind = KindRequest;
					r.su = 18'(u + dx * int'(step_q));
					r.sv = 18'(v + dy * int'(step_q));
					r.last = (k == KernelTaps - 1);
					shade_q.push_back(r);
					k++;
				end
			taps_due = KernelTaps;
			return;
		end
		if (taps_due == 0)
			return;
		if (int'(frag_z) - int'(bias_q) <= int'(it.sdepth))
			taps_lit++;
		taps_due--;
		if (taps_due == 0) begin
			shade_q.push_back(lit_result(taps_lit));
			taps_lit = 0;
		end
	endtask

	// input transfer seen at the rising edge
	bit in_xfer = 0;
	always @(posedge clk) in_xfer <= arst_n && s_tvalid && s_tready;

	// driver: bursts and gaps, items change on the falling edge
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_xfer) begin
				predict_shade(item_q.pop_front());
				burst_left = burst_left - 1;
			end
			if (gap_left > 0)
				gap_left = gap_left - 1;
			else if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
			end
			// an offered item stays until it is taken
			if (s_tvalid && !in_xfer)
				s_tvalid <= 1'b1;
			else if (!sender_hold && gap_left == 0 && item_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {item_q[0].sdepth, item_q[0].pz, item_q[0].py, item_q[0].px};
				s_tuser <= item_q[0].mode;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// sink stall pattern
	int sink_phase = 0;
	always @(negedge clk) begin
		sink_phase = sink_phase + 1;
		if (sink_block)
			m_tready <= 1'b0;
		else if (sink_phase % 200 < 60)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 2) != 0);
	end

	// monitor
	always @(posedge clk) begin
		shade_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.su = m_tdata[17:0];
			got.sv = m_tdata[35:18];
			got.cnt = m_tdata[39:36];
			got.frac = m_tdata[56:40];
			got.last = m_tlast;
			if (shade_q.size() == 0) begin
				$error("unexpected result transfer kind=%0d", got.kind);
				errors++;
			end else begin
				want = shade_q.pop_front();
				if (got.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
				end
				if (got.su !== want.su) begin
					$error("sample_u: expected %0d, got %0d", want.su, got.su); errors++;
				end
				if (got.sv !== want.sv) begin
					$error("sample_v: expected %0d, got %0d", want.sv, got.sv); errors++;
				end
				if (got.cnt !== want.cnt) begin
					$error("lit_count: expected %0d, got %0d", want.cnt, got.cnt); errors++;
				end
				if (got.frac !== want.frac) begin
					$error("lit_fraction: expected %0d, got %0d", want.frac, got.frac);
					errors++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, got.last); errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < 4) mat_row[idx] = val;
		else if (idx == RegBias) bias_q = val[15:0];
		else if (idx == RegStep) step_q = val[15:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (item_q.size() > 0 || shade_q.size() > 0 || s_tvalid) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// matrix entries Q4.12, packed column 0 low
	function automatic logic [63:0] mrow(int a, int b, int c, int d);
		return {16'(d), 16'(c), 16'(b), 16'(a)};
	endfunction

	task automatic add_frag(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		frag_item_t it;
		it = '0;
		it.mode = ModeFrag;
		it.px = x; it.py = y; it.pz = z;
		it.sdepth = 16'($urandom);
		item_q.push_back(it);
	endtask

	task automatic add_depth(logic [15:0] d);
		frag_item_t it;
		it = frag_item_t'(113'({$urandom, $urandom, $urandom, $urandom}));
		it.mode = 1'b1;
		it.sdepth = d;
		item_q.push_back(it);
	endtask

	// world coordinate that maps mostly inside the map for the set matrix
	function automatic logic [31:0] near_pos();
		return 32'($signed($urandom_range(0, 131072)) - 65536);
	endfunction

	task automatic random_phase(int n);
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				add_frag(near_pos(), near_pos(), near_pos());
				for (int t = 0; t < KernelTaps; t++)
					if ($urandom_range(0, 40) != 0)
						add_depth(($urandom_range(0, 3) == 0) ? 16'($urandom) :
							16'($urandom_range(20000, 45000)));
			end else if (kind < 9)
				add_frag($urandom, $urandom, $urandom);
			else
				add_depth(16'($urandom));
		end
	endtask

	initial begin
		mat_row = '{default: '0};
		bias_q = '0; step_q = '0; frag_z = '0;
		taps_due = 0; taps_lit = 0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset matrix gives w = 0: fully lit
		add_frag(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		add_depth(16'hFFFF);
		wait_idle();

		// scaled identity-like, z shifted into 0..1
		write_reg(RegRow0, mrow(2048, 0, 0, 2048));
		write_reg(RegRow1, mrow(0, 2048, 0, 2048));
		write_reg(RegRow2, mrow(0, 0, 1024, 2048));
		write_reg(RegRow3, mrow(0, 0, 0, 4096));
		write_reg(RegBias, 16'h0000);
		write_reg(RegStep, 16'hFFFF);
		add_frag(32'h0, 32'h0, 32'h0);
		for (int t = 0; t < KernelTaps; t++) add_depth((t % 2) ? 16'hFFFF : 16'h0);
		add_frag(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
		for (int t = 0; t < KernelTaps; t++) add_depth(16'h8000);
		add_frag(32'h0002_0000, 32'h0, 32'h0);
		// abandoned run: new fragment after four samples
		add_frag(32'h0, 32'h0, 32'hFFFF_0000);
		for (int t = 0; t < 4; t++) add_depth(16'h0);
		add_frag(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		wait_idle();

		write_reg(RegBias, 16'h8000);
		write_reg(RegStep, 16'h0000);
		write_reg(RegRow3, mrow(16'h8000, 16'h7FFF, 0, 16'h7FFF));
		random_phase(10);
		wait_idle();

		write_reg(RegBias, 16'h7FFF);
		write_reg(RegStep, 16'd512);
		write_reg(RegRow3, mrow(0, 0, 0, 4096));
		random_phase(8);
		// long sink stall while the sender keeps offering
		sink_block = 1;
		repeat (400) @(posedge clk);
		sink_block = 0;
		wait_idle();

		write_reg(RegBias, 16'd300);
		write_reg(RegRow0, mrow(4096, 0, 0, 0));
		write_reg(RegRow1, mrow(0, 4096, 0, 0));
		write_reg(RegRow2, mrow(0, 0, 2048, 2048));
		random_phase(4);
		// sender pauses until everything is out, then resumes
		sender_hold = 1;
		while (shade_q.size() > 0 || s_tvalid) @(posedge clk);
		sender_hold = 0;
		random_phase(4);
		wait_idle();

		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("testbench failed");
		$finish;
	end

endmodule

// File: pcf_shadow_test.f
src/pcf_pkg.sv
src/pcf_div.sv
src/pcf_shadow_test.sv
sim/testbench.sv
